>>> rtl/core/nun_pkg.sv
// ----------------------------------------------------------------------------
// nun_pkg
// Shared widths, codes and types for the 5-smooth number generator.
// ----------------------------------------------------------------------------
package nun_pkg;

    localparam int MAX_INDEX = 1024;
    localparam int INDEX_W   = 11;
    localparam int ADDR_W    = 10;
    localparam int VALUE_W   = 32;
    localparam int PROD_W    = VALUE_W + 3;

    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [1:0]         t_ptr_sel;

    localparam t_ptr_sel PTR_TWO   = 2'd0;
    localparam t_ptr_sel PTR_THREE = 2'd1;
    localparam t_ptr_sel PTR_FIVE  = 2'd2;

    typedef struct packed {
        logic     load;
        logic     rd;
        t_ptr_sel rd_sel;
        logic     cap2;
        logic     cap3;
        logic     step;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic target_one;
        logic fill_last;
    } t_sts;

    // scale by a small factor, saturating to all ones
    function automatic t_value f_sat_scale(input t_value v, input logic [2:0] k);
        logic [PROD_W-1:0] wide;
        wide = {3'b000, v} * {{(PROD_W-3){1'b0}}, k};
        if (wide[PROD_W-1:VALUE_W] != 3'b000) begin
            return '1;
        end
        return wide[VALUE_W-1:0];
    endfunction

endpackage

>>> rtl/core/nun_if.sv
// ----------------------------------------------------------------------------
// nun_if
// Valid/ready channels for query words and result words.
// ----------------------------------------------------------------------------
interface nun_query_if;
    logic            valid;
    logic            ready;
    nun_pkg::t_index query_index;

    modport source (output valid, output query_index, input ready);
    modport sink   (input valid, input query_index, output ready);
endinterface

interface nun_result_if;
    logic            valid;
    logic            ready;
    nun_pkg::t_value ugly_value;

    modport source (output valid, output ugly_value, input ready);
    modport sink   (input valid, input ugly_value, output ready);
endinterface

>>> rtl/core/nun_dp.sv
// ----------------------------------------------------------------------------
// nun_dp
// Datapath: sequence table, three pointers, candidate registers, result word.
// ----------------------------------------------------------------------------
module nun_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nun_pkg::t_cmd   i_cmd,
    input  nun_pkg::t_index i_query_index,
    output nun_pkg::t_sts   o_sts,
    output nun_pkg::t_value o_ugly_value
);

    nun_pkg::t_value r_table [0:nun_pkg::MAX_INDEX-1];

    nun_pkg::t_index r_target;
    nun_pkg::t_index r_fill;
    nun_pkg::t_addr  r_p2;
    nun_pkg::t_addr  r_p3;
    nun_pkg::t_addr  r_p5;
    nun_pkg::t_value r_rd_data;
    nun_pkg::t_value r_c2;
    nun_pkg::t_value r_c3;
    nun_pkg::t_value r_last;
    nun_pkg::t_value r_out;

    nun_pkg::t_index n_target;
    nun_pkg::t_addr  rd_addr;
    nun_pkg::t_addr  wr_addr;
    nun_pkg::t_value c5;
    nun_pkg::t_value least;
    nun_pkg::t_index fill_m1;

    always_comb begin
        if (i_query_index == '0) begin
            n_target = nun_pkg::INDEX_W'(1);
        end else if (i_query_index > nun_pkg::INDEX_W'(nun_pkg::MAX_INDEX)) begin
            n_target = nun_pkg::INDEX_W'(nun_pkg::MAX_INDEX);
        end else begin
            n_target = i_query_index;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            nun_pkg::PTR_TWO:   rd_addr = r_p2 - nun_pkg::ADDR_W'(1);
            nun_pkg::PTR_THREE: rd_addr = r_p3 - nun_pkg::ADDR_W'(1);
            nun_pkg::PTR_FIVE:  rd_addr = r_p5 - nun_pkg::ADDR_W'(1);
            default:            rd_addr = r_p2 - nun_pkg::ADDR_W'(1);
        endcase
    end

    assign fill_m1 = r_fill - nun_pkg::INDEX_W'(1);
    assign wr_addr = i_cmd.load ? '0 : fill_m1[nun_pkg::ADDR_W-1:0];

    always_comb begin
        c5    = nun_pkg::f_sat_scale(r_rd_data, 3'd5);
        least = (r_c2 < r_c3) ? r_c2 : r_c3;
        if (c5 < least) begin
            least = c5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.step) begin
            r_table[wr_addr] <= i_cmd.load ? nun_pkg::VALUE_W'(1) : least;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2   <= nun_pkg::ADDR_W'(1);
            r_p3   <= nun_pkg::ADDR_W'(1);
            r_p5   <= nun_pkg::ADDR_W'(1);
            r_fill <= nun_pkg::INDEX_W'(2);
        end else if (i_cmd.load) begin
            r_p2   <= nun_pkg::ADDR_W'(1);
            r_p3   <= nun_pkg::ADDR_W'(1);
            r_p5   <= nun_pkg::ADDR_W'(1);
            r_fill <= nun_pkg::INDEX_W'(2);
        end else if (i_cmd.step) begin
            if (r_c2 == least) begin
                r_p2 <= r_p2 + nun_pkg::ADDR_W'(1);
            end
            if (r_c3 == least) begin
                r_p3 <= r_p3 + nun_pkg::ADDR_W'(1);
            end
            if (c5 == least) begin
                r_p5 <= r_p5 + nun_pkg::ADDR_W'(1);
            end
            r_fill <= r_fill + nun_pkg::INDEX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= n_target;
            r_last   <= nun_pkg::VALUE_W'(1);
        end else if (i_cmd.step) begin
            r_last   <= least;
        end
        if (i_cmd.cap2) begin
            r_c2 <= nun_pkg::f_sat_scale(r_rd_data, 3'd2);
        end
        if (i_cmd.cap3) begin
            r_c3 <= nun_pkg::f_sat_scale(r_rd_data, 3'd3);
        end
        if (i_cmd.emit) begin
            r_out <= r_last;
        end
    end

    assign o_sts.target_one = (r_target == nun_pkg::INDEX_W'(1));
    assign o_sts.fill_last  = (r_fill == r_target);
    assign o_ugly_value     = r_out;

endmodule

>>> rtl/core/nun_ctrl.sv
// ----------------------------------------------------------------------------
// nun_ctrl
// Controller: sequences table reads, entry writes and the result word.
// ----------------------------------------------------------------------------
module nun_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  nun_pkg::t_sts i_sts,
    output nun_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_RD2   = 3'd2;
    localparam logic [2:0] S_RD3   = 3'd3;
    localparam logic [2:0] S_RD5   = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = nun_pkg::PTR_TWO;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_state = i_sts.target_one ? S_FIN : S_RD2;
            end
            S_RD2: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = nun_pkg::PTR_TWO;
                n_state      = S_RD3;
            end
            S_RD3: begin
                o_cmd.cap2   = 1'b1;
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = nun_pkg::PTR_THREE;
                n_state      = S_RD5;
            end
            S_RD5: begin
                o_cmd.cap3   = 1'b1;
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = nun_pkg::PTR_FIVE;
                n_state      = S_WR;
            end
            S_WR: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.fill_last ? S_FIN : S_RD2;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/nth_ugly_number.sv
// ----------------------------------------------------------------------------
// nth_ugly_number
// Returns the n-th 5-smooth number, counting 1 as the first.
// ----------------------------------------------------------------------------
// Query channel i_query carries query_index; result channel o_result carries
// ugly_value, one result word per query word. Index zero reads as one and an
// index above 1024 reads as 1024.
// Each query rebuilds the sequence table in a single-port memory. Every new
// entry is built from three reads of the table, one for each pointer,
// then the compare and write. The next query is taken the cycle after the
// result word leaves the controller for the output register.
// i_query.ready is high only while no query is in progress.
// When o_result is stalled, the block still takes and computes the next
// query, then holds it until the output register frees.
// Reset is synchronous: the channels come up empty and idle. The table
// needs no clearing, since every query writes each entry before reading it.
// ----------------------------------------------------------------------------
module nth_ugly_number (
    input  logic i_clk,
    input  logic i_rst_n,
    nun_query_if.sink    i_query,
    nun_result_if.source o_result
);

    nun_pkg::t_cmd cmd;
    nun_pkg::t_sts sts;

    nun_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_query.valid),
        .o_in_ready  (i_query.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    nun_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_query_index (i_query.query_index),
        .o_sts         (sts),
        .o_ugly_value  (o_result.ugly_value)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.cap2, cmd.cap3, cmd.step, cmd.emit}))
        else $error("more than one datapath command at once");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_query.valid && i_query.ready) |-> cmd.load)
        else $error("accepted query word not loaded");

    a_step_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> $past(cmd.cap3))
        else $error("entry write without preceding candidate reads");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_result.valid || o_result.ready))
        else $error("result word overwritten while stalled");

    a_value_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.ugly_value != '0))
        else $error("zero result word");

endmodule

>>> bench/nth_ugly_number_tb.sv
// ----------------------------------------------------------------------------
// nth_ugly_number_tb
// Self-checking bench for the n-th 5-smooth number generator.
// ----------------------------------------------------------------------------
// Query words go in on a valid/ready channel with random gaps and no-gap
// bursts. Result words come out against a randomly stalling receiver, with
// two long receiver hold-offs that back the block up into its query port.
// A scoreboard rebuilds the sequence for each accepted query and compares
// every result word in order.
// ----------------------------------------------------------------------------
module nth_ugly_number_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned VALUE_ALL_ONES = (64'd1 << nun_pkg::VALUE_W) - 64'd1;
    localparam int DRAIN_CYCLES = 4200;

    class smooth_scoreboard;
        logic [63:0]     seq_tbl [1:nun_pkg::MAX_INDEX];
        int unsigned     ptr_two;
        int unsigned     ptr_three;
        int unsigned     ptr_five;
        int unsigned     fill_pos;
        nun_pkg::t_value expected_q[$];
        int unsigned     mismatches;

        function new();
            ptr_two    = 1;
            ptr_three  = 1;
            ptr_five   = 1;
            fill_pos   = 2;
            mismatches = 0;
        endfunction

        function logic [63:0] scaled(input logic [63:0] v, input int unsigned k);
            if (v > VALUE_ALL_ONES / k) begin
                return VALUE_ALL_ONES;
            end
            return v * k;
        endfunction

        // rebuild the table up to the clamped index and queue its entry
        function void note_query(input nun_pkg::t_index idx);
            int unsigned target;
            logic [63:0] c2;
            logic [63:0] c3;
            logic [63:0] c5;
            logic [63:0] least;
            target = idx;
            if (target == 0) begin
                target = 1;
            end
            if (target > nun_pkg::MAX_INDEX) begin
                target = nun_pkg::MAX_INDEX;
            end
            seq_tbl[1] = 64'd1;
            ptr_two    = 1;
            ptr_three  = 1;
            ptr_five   = 1;
            for (fill_pos = 2; fill_pos <= target; fill_pos++) begin
                c2    = scaled(seq_tbl[ptr_two], 2);
                c3    = scaled(seq_tbl[ptr_three], 3);
                c5    = scaled(seq_tbl[ptr_five], 5);
                least = (c2 < c3) ? c2 : c3;
                if (c5 < least) begin
                    least = c5;
                end
                seq_tbl[fill_pos] = least;
                if (c2 == least) begin
                    ptr_two++;
                end
                if (c3 == least) begin
                    ptr_three++;
                end
                if (c5 == least) begin
                    ptr_five++;
                end
            end
            expected_q.push_back(seq_tbl[target][nun_pkg::VALUE_W-1:0]);
        endfunction

        function void check_result(input nun_pkg::t_value got);
            nun_pkg::t_value want;
            if (expected_q.size() == 0) begin
                $error("ugly_value: no query outstanding, actual %0d", got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                $error("ugly_value mismatch: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    nun_query_if  query_ch ();
    nun_result_if result_ch ();

    smooth_scoreboard sb = new();

    nth_ugly_number dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_query (query_ch),
        .o_result(result_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("nth_ugly_number verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && query_ch.valid && query_ch.ready) begin
            sb.note_query(query_ch.query_index);
        end
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            sb.check_result(result_ch.ugly_value);
        end
    end

    task automatic send_query(input nun_pkg::t_index idx, input bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            query_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        query_ch.valid       <= 1'b1;
        query_ch.query_index <= idx;
        do @(posedge i_clk); while (!query_ch.ready);
    endtask

    function automatic nun_pkg::t_index pick_index();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return nun_pkg::t_index'($urandom_range(1, 48));
        end else if (roll < 85) begin
            return nun_pkg::t_index'($urandom_range(49, 300));
        end else if (roll < 93) begin
            return nun_pkg::t_index'($urandom_range(301, nun_pkg::MAX_INDEX));
        end else if (roll < 96) begin
            return '0;
        end
        return nun_pkg::t_index'($urandom_range(nun_pkg::MAX_INDEX + 1, 2047));
    endfunction

    // receiver: random stalls, no-stall bursts, two long hold-offs
    initial begin
        int unsigned taken;
        int unsigned gap;
        taken = 0;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = ((taken / 20) % 3 == 2) ? 0 : $urandom_range(0, 8);
            if (taken == 30 || taken == 140) begin
                gap = 1500;
            end
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            taken++;
        end
    end

    initial begin
        nun_pkg::t_index directed [18];
        int unsigned sent;
        directed = '{11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd6, 11'd7, 11'd0,
                     11'd1024, 11'd1025, 11'd2047, 11'd1023, 11'd512, 11'd256,
                     11'd10, 11'd11, 11'd150, 11'd1000};
        sent = 0;
        i_rst_n              <= 1'b0;
        query_ch.valid       <= 1'b0;
        query_ch.query_index <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_query(directed[k], 1'b0);
            sent++;
        end
        repeat (172) begin
            send_query(pick_index(), ((sent / 20) % 3) == 1);
            sent++;
        end
        query_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("nth_ugly_number verification clean");
        end else begin
            $display("nth_ugly_number verification failed");
        end
        $finish;
    end

endmodule
